[hw/rtl/dfs_pkg.sv]
package dfs_pkg;

	localparam int DEF_MAX_FIELD_LEN = 1024;
	localparam int DEF_MAX_FIELDS    = 256;

	localparam logic [7:0] CH_NEWLINE = 8'd10;
	localparam logic [7:0] CH_SPACE   = 8'd32;
	localparam logic [7:0] CH_TAB     = 8'd9;
	localparam logic [7:0] CH_CR      = 8'd13;

	localparam logic [1:0] REG_SEPARATOR = 2'd0;
	localparam logic [1:0] REG_QUOTE     = 2'd1;
	localparam logic [1:0] REG_RTRIM     = 2'd2;

	typedef struct packed {
		logic [7:0] separator_char;
		logic [7:0] quote_char;
		logic       rtrim_enable;
	} cfg_t;

	typedef struct packed {
		logic [7:0]  out_byte;
		logic        byte_valid;
		logic [9:0]  byte_position;
		logic        field_end;
		logic        record_end;
		logic [7:0]  field_index;
		logic [10:0] field_length;
		logic        was_quoted;
		logic        quote_error;
		logic        overlong;
	} result_t;

	function automatic logic is_ws(input logic [7:0] b);
		return (b == CH_SPACE) || ((b >= CH_TAB) && (b <= CH_CR));
	endfunction

endpackage

[hw/rtl/dfs_parse.sv]
module dfs_parse import dfs_pkg::*; #(
	parameter int MAX_FIELD_LEN = DEF_MAX_FIELD_LEN,
	parameter int MAX_FIELDS    = DEF_MAX_FIELDS
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       step,
	input  logic [7:0] in_byte,
	input  logic       eod,
	input  cfg_t       cfg,
	output logic       res_vld,
	output result_t    res
);

	localparam int PW = $clog2(MAX_FIELD_LEN + 1);
	localparam int FW = $clog2(MAX_FIELDS);
	localparam logic [PW-1:0] POS_MAX = PW'(MAX_FIELD_LEN);
	localparam logic [FW-1:0] CNT_MAX = FW'(MAX_FIELDS - 1);

	typedef enum logic [2:0] {
		M_START  = 3'd0,
		M_PLAIN  = 3'd1,
		M_QUOTED = 3'd2,
		M_QSEEN  = 3'd3,
		M_AFTERQ = 3'd4,
		M_JUNK   = 3'd5,
		M_SKIPWS = 3'd6
	} mode_t;

	typedef enum logic [1:0] {
		A_NONE,
		A_CONTENT,
		A_CLOSE,
		A_MARKER
	} act_t;

	mode_t         mode_q, mode_d, next_mode;
	logic [PW-1:0] pos_q, pos_d, pos_e;
	logic [PW-1:0] trail_q, trail_d, trail_e;
	logic [FW-1:0] cnt_q, cnt_d;
	logic          ovl_q, ovl_d, ovl_e;

	act_t          act;
	logic          rec, clr;
	logic          nl, sm, ws, sep_hit, qhit, quoted;
	logic [PW-1:0] len;

	assign nl      = (in_byte == CH_NEWLINE);
	assign sm      = (cfg.separator_char == CH_SPACE);
	assign ws      = is_ws(in_byte);
	assign sep_hit = !sm && (in_byte == cfg.separator_char);
	assign qhit    = (cfg.quote_char != 8'd0) && (in_byte == cfg.quote_char);
	assign quoted  = (mode_q == M_QUOTED) || (mode_q == M_QSEEN) ||
			(mode_q == M_AFTERQ) || (mode_q == M_JUNK);

	always_comb begin
		act       = A_NONE;
		rec       = 1'b0;
		clr       = 1'b0;
		next_mode = mode_q;
		if (eod) begin
			case (mode_q)
				M_SKIPWS: begin
					next_mode = M_START;
					if (cnt_q != '0) act = A_MARKER;
				end
				M_PLAIN, M_QUOTED, M_QSEEN, M_AFTERQ, M_JUNK: begin
					act = A_CLOSE;
					rec = 1'b1;
					next_mode = M_START;
				end
				default: begin
					next_mode = M_START;
					if (cnt_q != '0) begin
						act = A_CLOSE;
						rec = 1'b1;
					end else begin
						clr = 1'b1;
					end
				end
			endcase
		end else begin
			case (mode_q)
				M_PLAIN, M_JUNK: begin
					if (nl) begin
						act = A_CLOSE;
						rec = 1'b1;
						next_mode = M_START;
					end else if (sm && ws) begin
						act = A_CLOSE;
						next_mode = M_SKIPWS;
					end else if (sep_hit) begin
						act = A_CLOSE;
						next_mode = M_START;
					end else if (mode_q == M_PLAIN) begin
						act = A_CONTENT;
					end
				end
				M_QUOTED: begin
					if (qhit) next_mode = M_QSEEN;
					else act = A_CONTENT;
				end
				M_QSEEN, M_AFTERQ: begin
					if ((mode_q == M_QSEEN) && qhit) begin
						act = A_CONTENT;
						next_mode = M_QUOTED;
					end else if (nl) begin
						act = A_CLOSE;
						rec = 1'b1;
						next_mode = M_START;
					end else if (sm && ws) begin
						act = A_CLOSE;
						next_mode = M_SKIPWS;
					end else if (sep_hit) begin
						act = A_CLOSE;
						next_mode = M_START;
					end else if (!sm && (in_byte == CH_SPACE)) begin
						next_mode = M_AFTERQ;
					end else begin
						next_mode = M_JUNK;
					end
				end
				default: begin
					if (qhit) begin
						clr = 1'b1;
						next_mode = M_QUOTED;
					end else if (nl) begin
						next_mode = M_START;
						if (mode_q == M_SKIPWS) begin
							act = A_MARKER;
						end else begin
							act = A_CLOSE;
							rec = 1'b1;
						end
					end else if (sm && ws) begin
						if (mode_q != M_SKIPWS) begin
							act = A_CLOSE;
							next_mode = M_SKIPWS;
						end
					end else if (sep_hit) begin
						act = A_CLOSE;
						next_mode = M_START;
					end else begin
						clr = 1'b1;
						act = A_CONTENT;
						next_mode = M_PLAIN;
					end
				end
			endcase
		end
	end

	assign pos_e   = clr ? '0 : pos_q;
	assign trail_e = clr ? '0 : trail_q;
	assign ovl_e   = clr ? 1'b0 : ovl_q;
	assign len     = (cfg.rtrim_enable && !quoted) ? (pos_q - trail_q) : pos_q;

	always_comb begin
		res     = '0;
		res_vld = 1'b0;
		mode_d  = next_mode;
		pos_d   = pos_e;
		trail_d = trail_e;
		ovl_d   = ovl_e;
		cnt_d   = cnt_q;
		case (act)
			A_CONTENT: begin
				if (pos_e >= POS_MAX) begin
					ovl_d = 1'b1;
				end else begin
					res_vld           = 1'b1;
					res.out_byte      = in_byte;
					res.byte_valid    = 1'b1;
					res.byte_position = 10'(pos_e);
					res.field_index   = 8'(cnt_q);
					pos_d             = pos_e + 1'b1;
					if (in_byte == CH_SPACE) begin
						if (trail_e < POS_MAX) trail_d = trail_e + 1'b1;
					end else begin
						trail_d = '0;
					end
				end
			end
			A_CLOSE: begin
				res_vld          = 1'b1;
				res.field_end    = 1'b1;
				res.record_end   = rec;
				res.field_index  = 8'(cnt_q);
				res.field_length = 11'(len);
				res.was_quoted   = quoted;
				res.quote_error  = (mode_q == M_JUNK);
				res.overlong     = ovl_q;
				if (rec) cnt_d = '0;
				else if (cnt_q < CNT_MAX) cnt_d = cnt_q + 1'b1;
				pos_d   = '0;
				trail_d = '0;
				ovl_d   = 1'b0;
			end
			A_MARKER: begin
				res_vld         = 1'b1;
				res.record_end  = 1'b1;
				res.field_index = 8'(cnt_q);
				cnt_d   = '0;
				pos_d   = '0;
				trail_d = '0;
				ovl_d   = 1'b0;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= M_START;
			pos_q   <= '0;
			trail_q <= '0;
			cnt_q   <= '0;
			ovl_q   <= 1'b0;
		end else if (step) begin
			mode_q  <= mode_d;
			pos_q   <= pos_d;
			trail_q <= trail_d;
			cnt_q   <= cnt_d;
			ovl_q   <= ovl_d;
		end
	end

endmodule

[hw/rtl/delimited_field_splitter_top.sv]
// Delimited field splitter: splits a byte stream into fields and records.
// Input channel: in_valid/in_stall carry one word per handshake, either a
// text byte (in_byte) or an end-of-data mark (end_of_data high).
// Output channel: out_valid/out_stall carry zero or one result word per
// input word: a content byte with its offset, an end-of-field word with
// index and length, or a record marker.
// Configuration: write separator, quote and trim registers through
// cfg_we/cfg_index/cfg_data while the block is idle.
// Throughput: one input word per cycle while in_stall is low, set by the
// single-pass parser between the input register and the output register.
// Path: an accepted input word loads the input register; the parser result
// then loads the output register, or the skid register if that one is held.
// Stall: results back up into a one-word skid register; in_stall rises
// only when the skid register is full and the input register holds a word.
// Reset: registers return to separator 9, quoting off, trim off; the parser
// returns to field start with counters cleared; all buffers empty.
module delimited_field_splitter_top import dfs_pkg::*; #(
	parameter int MAX_FIELD_LEN = DEF_MAX_FIELD_LEN,
	parameter int MAX_FIELDS    = DEF_MAX_FIELDS
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [7:0]  cfg_data,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  in_byte,
	input  logic        end_of_data,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [7:0]  out_byte,
	output logic        byte_valid,
	output logic [9:0]  byte_position,
	output logic        field_end,
	output logic        record_end,
	output logic [7:0]  field_index,
	output logic [10:0] field_length,
	output logic        was_quoted,
	output logic        quote_error,
	output logic        overlong
);

	cfg_t       cfg_q;
	logic [7:0] byte_s1;
	logic       eod_s1;
	logic       vld_s1;
	logic       step;
	logic       res_vld;
	result_t    res;
	result_t    out_q, skid_q;
	logic       out_vld_q, skid_vld_q;
	logic       take;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.separator_char <= CH_TAB;
			cfg_q.quote_char     <= 8'd0;
			cfg_q.rtrim_enable   <= 1'b0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_SEPARATOR: cfg_q.separator_char <= cfg_data;
				REG_QUOTE:     cfg_q.quote_char     <= cfg_data;
				REG_RTRIM:     cfg_q.rtrim_enable   <= cfg_data[0];
				default: begin
				end
			endcase
		end
	end

	assign in_stall = vld_s1 && skid_vld_q;
	assign step     = vld_s1 && !skid_vld_q;
	assign take     = out_vld_q && !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (!in_stall) begin
			vld_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			byte_s1 <= in_byte;
			eod_s1  <= end_of_data;
		end
	end

	dfs_parse #(
		.MAX_FIELD_LEN(MAX_FIELD_LEN),
		.MAX_FIELDS   (MAX_FIELDS)
	) u_parse (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (step),
		.in_byte(byte_s1),
		.eod    (eod_s1),
		.cfg    (cfg_q),
		.res_vld(res_vld),
		.res    (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q  <= 1'b0;
			skid_vld_q <= 1'b0;
		end else if (skid_vld_q) begin
			if (take) skid_vld_q <= 1'b0;
		end else if (step && res_vld) begin
			if (!out_vld_q || take) out_vld_q <= 1'b1;
			else skid_vld_q <= 1'b1;
		end else if (take) begin
			out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (skid_vld_q) begin
			if (take) out_q <= skid_q;
		end else if (step && res_vld) begin
			if (!out_vld_q || take) out_q <= res;
			else skid_q <= res;
		end
	end

	assign out_valid     = out_vld_q;
	assign out_byte      = out_q.out_byte;
	assign byte_valid    = out_q.byte_valid;
	assign byte_position = out_q.byte_position;
	assign field_end     = out_q.field_end;
	assign record_end    = out_q.record_end;
	assign field_index   = out_q.field_index;
	assign field_length  = out_q.field_length;
	assign was_quoted    = out_q.was_quoted;
	assign quote_error   = out_q.quote_error;
	assign overlong      = out_q.overlong;

endmodule
